@@ rtl/lzss_window_decompressor_assert.svh @@
// assertion macros for the lzss window decompressor checker
// no dependencies; included by the checker file
`ifndef LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH

// property checked outside reset
`define LZSSWD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lzsswd assertion failed");

// property checked at every edge, reset included
`define LZSSWD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lzsswd assertion failed");

`endif

@@ rtl/lzsswd_pkg.sv @@
// types and constants for the lzss window decompressor
// no dependencies; used by the top level and the checker
package lzsswd_pkg;

  localparam int HistAw = 12;
  localparam int CountW = 24;

  localparam logic [HistAw-1:0] OffsetBias = 12'd18;
  localparam logic [CountW-1:0] CountMax   = 24'hFFFFFF;
  localparam logic [3:0]        FlagCount  = 4'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_of_block;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last_of_run;
    logic [CountW-1:0] produced_count;
  } out_t;

endpackage

@@ rtl/lzss_window_decompressor.sv @@
// lzss decoder with a 4096-byte history held in one block memory
// depends on lzsswd_pkg
//
//   channel | signals                      | carries
//   cmp     | cmp_valid, cmp_ready, cmp    | compressed bytes with end-of-block mark
//   raw     | raw_valid, raw_ready, raw    | decoded bytes with run end and count
//
// control byte and first match byte: taken in the idle state, ready again at once
// literal: one emit step; match of length n: a distance step, then a history read and an emit step per byte
// rst clears the decoder state; history contents are not cleared
// a full output register stalls the emit step and holds off the next request;
// only the last byte of a request may still wait there when the next one is taken
module lzss_window_decompressor (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmp_valid,
  output logic              cmp_ready,
  input  lzsswd_pkg::in_t   cmp,
  output logic              raw_valid,
  input  logic              raw_ready,
  output lzsswd_pkg::out_t  raw
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LIT  = 3'd1;
  localparam logic [2:0] ST_DIST = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam int Aw = lzsswd_pkg::HistAw;
  localparam int Cw = lzsswd_pkg::CountW;

  logic [7:0] hist [0:(1<<Aw)-1];

  logic [2:0]    state;
  logic [7:0]    flag_byte;
  logic [3:0]    flags_left;
  logic [7:0]    offset_low;
  logic          awaiting_second;
  logic [Aw-1:0] write_pos;
  logic [Cw-1:0] block_bytes;
  logic [7:0]    lit_byte;
  logic [Aw-1:0] src_ptr;
  logic [Aw:0]   copy_dist;
  logic [4:0]    cnt;
  logic          clear_pending;
  logic [7:0]    rd_data;
  logic          zero_fill;

  // shared 12-bit adder: match source start, distance, source step
  logic [Aw-1:0] add_a;
  logic [Aw-1:0] add_b;
  logic          add_ci;
  logic [Aw-1:0] add_out;

  logic          accept;
  logic          out_free;
  logic          emit;
  logic          emit_last;
  logic [7:0]    emit_val;
  logic [Cw-1:0] count_next;

  assign cmp_ready = (state == ST_IDLE);
  assign accept    = cmp_valid && cmp_ready;
  assign out_free  = !raw_valid || raw_ready;
  assign emit      = ((state == ST_LIT) || (state == ST_EMIT)) && out_free;
  assign emit_last = (state == ST_LIT) || (cnt == 5'd0);
  assign emit_val  = (state == ST_LIT) ? lit_byte : (zero_fill ? 8'd0 : rd_data);
  assign count_next = (block_bytes == lzsswd_pkg::CountMax) ? block_bytes
                                                            : block_bytes + 1'b1;

  always_comb begin
    case (state)
      ST_IDLE: begin
        add_a  = {cmp.in_byte[7:4], offset_low};
        add_b  = lzsswd_pkg::OffsetBias;
        add_ci = 1'b0;
      end
      ST_DIST: begin
        add_a  = write_pos;
        add_b  = ~src_ptr;
        add_ci = 1'b1;
      end
      default: begin
        add_a  = src_ptr;
        add_b  = '0;
        add_ci = 1'b1;
      end
    endcase
    add_out = add_a + add_b + {{(Aw-1){1'b0}}, add_ci};
  end

  // history memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (emit) begin
      hist[write_pos] <= emit_val;
    end
    if (state == ST_READ) begin
      rd_data <= hist[src_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit_byte <= cmp.in_byte;
    end
    if (state == ST_READ) begin
      zero_fill <= block_bytes < {{(Cw-Aw-1){1'b0}}, copy_dist};
    end
    if (emit) begin
      raw.out_byte       <= emit_val;
      raw.last_of_run    <= emit_last;
      raw.produced_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      flag_byte       <= '0;
      flags_left      <= '0;
      offset_low      <= '0;
      awaiting_second <= 1'b0;
      write_pos       <= '0;
      block_bytes     <= '0;
      src_ptr         <= '0;
      copy_dist       <= '0;
      cnt             <= '0;
      clear_pending   <= 1'b0;
      raw_valid       <= 1'b0;
    end else begin
      if (emit) begin
        raw_valid <= 1'b1;
      end else if (raw_ready) begin
        raw_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            clear_pending <= cmp.last_of_block;
            // block ends on a request that emits nothing
            if (cmp.last_of_block && ((flags_left == 4'd0) ||
                (!flag_byte[0] && !awaiting_second))) begin
              flag_byte       <= '0;
              flags_left      <= '0;
              offset_low      <= '0;
              awaiting_second <= 1'b0;
              write_pos       <= '0;
              block_bytes     <= '0;
            end else if (flags_left == 4'd0) begin
              flag_byte  <= cmp.in_byte;
              flags_left <= lzsswd_pkg::FlagCount;
            end else if (flag_byte[0]) begin
              state <= ST_LIT;
            end else if (!awaiting_second) begin
              offset_low      <= cmp.in_byte;
              awaiting_second <= 1'b1;
            end else begin
              src_ptr <= add_out;
              cnt     <= {1'b0, cmp.in_byte[3:0]} + 5'd2;
              state   <= ST_DIST;
            end
          end
        end
        ST_DIST: begin
          // a distance of zero reaches a full window back
          copy_dist <= {(add_out == '0), add_out};
          state     <= ST_READ;
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_LIT, ST_EMIT: begin
          if (emit) begin
            if (emit_last) begin
              state           <= ST_IDLE;
              awaiting_second <= 1'b0;
              if (clear_pending) begin
                flag_byte   <= '0;
                flags_left  <= '0;
                offset_low  <= '0;
                write_pos   <= '0;
                block_bytes <= '0;
              end else begin
                write_pos   <= write_pos + 1'b1;
                block_bytes <= count_next;
                flag_byte   <= {1'b0, flag_byte[7:1]};
                flags_left  <= flags_left - 1'b1;
              end
            end else begin
              write_pos   <= write_pos + 1'b1;
              block_bytes <= count_next;
              cnt         <= cnt - 1'b1;
              src_ptr     <= add_out;
              state       <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/lzsswd_checker.sv @@
// port-level checks for the lzss window decompressor, bound to the top level
// depends on lzsswd_pkg and lzss_window_decompressor_assert.svh
`include "lzss_window_decompressor_assert.svh"

module lzsswd_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmp_valid,
  input logic             cmp_ready,
  input lzsswd_pkg::in_t  cmp,
  input logic             raw_valid,
  input logic             raw_ready,
  input lzsswd_pkg::out_t raw
);

  // a stalled output byte holds
  `LZSSWD_ASSERT(a_raw_hold, clk, rst, raw_valid && !raw_ready |=> raw_valid && $stable(raw))

  // inside a match run no new request is taken
  `LZSSWD_ASSERT(a_busy_mid_run, clk, rst, raw_valid && !raw.last_of_run |-> !cmp_ready)

  // every emitted byte counts itself
  `LZSSWD_ASSERT(a_count_nonzero, clk, rst, raw_valid |-> raw.produced_count != 24'd0)

  // reset leaves the block empty and ready
  `LZSSWD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !raw_valid && cmp_ready)

endmodule

bind lzss_window_decompressor lzsswd_checker u_lzsswd_checker (.*);

@@ tb/lzss_window_decompressor_checker.sv @@
`timescale 1ns / 100ps
// checker for the lzss window decompressor: decodes each accepted compressed byte
// and compares every accepted raw byte with the oldest expected one; uses lzsswd_pkg
module lzss_window_decompressor_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmp_valid,
  input  logic             cmp_ready,
  input  lzsswd_pkg::in_t  cmp,
  input  logic             raw_valid,
  input  logic             raw_ready,
  input  lzsswd_pkg::out_t raw,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  localparam int          Aw          = lzsswd_pkg::HistAw;
  localparam int          Cw          = lzsswd_pkg::CountW;
  localparam logic [4:0]  MinMatch    = 5'd3;
  localparam logic [Aw:0] WindowDepth = {1'b1, {Aw{1'b0}}};

  // decoder state
  logic [7:0]    window [1 << Aw];
  logic [Aw-1:0] wr_pos;
  logic [Cw-1:0] out_count;
  logic [7:0]    flag_bits;
  logic [3:0]    flags_left;
  logic [7:0]    offset_lo;
  logic          mid_match;

  lzsswd_pkg::out_t run_q[$];
  lzsswd_pkg::out_t expected_bytes[$];
  int   n_bad = 0;
  int   n_checked = 0;

  task automatic clear_state();
    wr_pos     = '0;
    out_count  = '0;
    flag_bits  = '0;
    flags_left = '0;
    offset_lo  = '0;
    mid_match  = 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    lzsswd_pkg::out_t res;
    window[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
    if (out_count != lzsswd_pkg::CountMax) out_count = out_count + 1'b1;
    res.out_byte       = b;
    res.last_of_run    = 1'b0;
    res.produced_count = out_count;
    run_q.push_back(res);
  endtask

  task automatic take_flag();
    flag_bits = flag_bits >> 1;
    if (flags_left != 0) flags_left = flags_left - 1'b1;
  endtask

  task automatic decode(input lzsswd_pkg::in_t req);
    logic [Aw-1:0]    offs;
    logic [Aw-1:0]    rd_pos;
    logic [Aw:0]      span;
    logic [4:0]       len;
    lzsswd_pkg::out_t res;
    run_q.delete();
    if (flags_left == 0) begin
      flag_bits  = req.in_byte;
      flags_left = lzsswd_pkg::FlagCount;
    end else if (flag_bits[0]) begin
      put_byte(req.in_byte);
      take_flag();
    end else if (!mid_match) begin
      offset_lo = req.in_byte;
      mid_match = 1'b1;
    end else begin
      offs = {req.in_byte[7:4], offset_lo};
      len  = MinMatch + {1'b0, req.in_byte[3:0]};
      span = {1'b0, wr_pos - offs - lzsswd_pkg::OffsetBias};
      // zero distance reaches a full window back
      if (span == 0) span = WindowDepth;
      for (int i = 0; i < len; i++) begin
        rd_pos = wr_pos - span[Aw-1:0];
        // source before the block start reads as zero
        put_byte((out_count < span) ? 8'h00 : window[rd_pos]);
      end
      mid_match = 1'b0;
      take_flag();
    end
    if (run_q.size() > 0) begin
      res = run_q.pop_back();
      res.last_of_run = 1'b1;
      run_q.push_back(res);
    end
    foreach (run_q[i]) expected_bytes.push_back(run_q[i]);
    if (req.last_of_block) clear_state();
  endtask

  task automatic check_result(input lzsswd_pkg::out_t got);
    lzsswd_pkg::out_t want;
    if (expected_bytes.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t checker: unexpected raw byte %02h last %0b count %0d",
                 $time, got.out_byte, got.last_of_run, got.produced_count);
    end else begin
      want = expected_bytes.pop_front();
      n_checked++;
      if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
          got.produced_count !== want.produced_count) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t checker: byte %02h/%02h last %0b/%0b count %0d/%0d (exp/act)",
                   $time, want.out_byte, got.out_byte, want.last_of_run, got.last_of_run,
                   want.produced_count, got.produced_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_bytes.delete();
    end else begin
      if (cmp_valid && cmp_ready) decode(cmp);
      if (raw_valid && raw_ready) check_result(raw);
    end
    pending    <= expected_bytes.size();
    fail_count <= n_bad;
    checked    <= n_checked;
  end

endmodule

@@ tb/lzss_window_decompressor_tb.sv @@
`timescale 1ns / 100ps
// top of the lzss window decompressor testbench: clock, reset, compressed streams
// and the verdict; depends on lzsswd_pkg, the block and lzss_window_decompressor_checker
module lzss_window_decompressor_tb;

  localparam int         LongHold       = 400;
  localparam int         WindowSize     = 4096;
  localparam int         MatchBias      = 18;
  localparam int         MinMatch       = 3;
  localparam int         LongBlockBytes = 4200;
  localparam int         RandomUntil    = 100;
  localparam logic [7:0] AllMatches     = 8'h00;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmp_valid = 1'b0;
  logic             cmp_ready;
  lzsswd_pkg::in_t  cmp = '0;
  logic             raw_valid;
  logic             raw_ready = 1'b0;
  lzsswd_pkg::out_t raw;

  int fail_count;
  int pending;
  int checked;

  int         sent = 0;
  int         blocks = 0;
  int         gen_prod = 0;
  bit         tx_calm = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] grp_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lzss_window_decompressor dut (
    .clk       (clk),
    .rst       (rst),
    .cmp_valid (cmp_valid),
    .cmp_ready (cmp_ready),
    .cmp       (cmp),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .raw       (raw)
  );

  lzss_window_decompressor_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmp_valid  (cmp_valid),
    .cmp_ready  (cmp_ready),
    .cmp        (cmp),
    .raw_valid  (raw_valid),
    .raw_ready  (raw_ready),
    .raw        (raw),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_distance(input bit dense);
    int avail;
    int r;
    avail = (gen_prod < WindowSize) ? gen_prod : WindowSize;
    r = $urandom_range(0, 99);
    if (avail > 0 && r < 40) return $urandom_range(1, (avail < 24) ? avail : 24);
    if (avail > 0 && r < (dense ? 85 : 70)) return $urandom_range(1, avail);
    if (r < 90) return WindowSize;
    return $urandom_range(1, WindowSize);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      cmp_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmp_valid <= 1'b1;
    cmp <= {b, lst};
    do @(posedge clk); while (!cmp_ready);
    sent++;
  endtask

  task automatic drain();
    cmp_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // one control byte and its eight literals or matches
  task automatic build_group(input logic [7:0] flags, input bit dense);
    logic [11:0] offs;
    logic [3:0]  len_code;
    logic [7:0]  lit;
    grp_q.delete();
    grp_q.push_back(flags);
    for (int i = 0; i < 8; i++) begin
      if (flags[i]) begin
        lit = 8'($urandom);
        grp_q.push_back(lit);
        gen_prod++;
      end else begin
        len_code = (dense && $urandom_range(0, 15) != 0) ? 4'hF
                                                         : 4'($urandom_range(0, 15));
        offs = 12'(gen_prod - pick_distance(dense) - MatchBias);
        grp_q.push_back(offs[7:0]);
        grp_q.push_back({offs[11:8], len_code});
        gen_prod += len_code + MinMatch;
      end
    end
  endtask

  // dense blocks run on until they pass the window size
  task automatic send_block(input int n_groups, input bit dense);
    int         g;
    int         cut;
    bit         done;
    logic [7:0] flags;
    gen_prod = 0;
    g = 0;
    done = 1'b0;
    while (!done) begin
      flags = 8'($urandom);
      if (dense && $urandom_range(0, 9) != 0) flags = AllMatches;
      build_group(flags, dense);
      g++;
      done = dense ? (gen_prod >= LongBlockBytes) : (g >= n_groups);
      cut = grp_q.size();
      // some blocks stop short, even inside a match
      if (done && $urandom_range(0, 9) < 4) cut = $urandom_range(1, grp_q.size());
      for (int i = 0; i < cut; i++) send_byte(grp_q[i], done && i == cut - 1);
    end
    blocks++;
  endtask

  task automatic send_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      send_byte(b, i == n - 1);
    end
    blocks++;
  endtask

  initial begin
    int  gap;
    bit  calm;
    bit  held;
    calm = 1'b0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        raw_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        gap = pick_gap(calm);
        if (gap > 0) begin
          raw_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      raw_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 15) == 0) calm = !calm;
    end
  end

  initial begin
    int wait_cycles;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // literals at both extremes, overlapping copy, zero distance before the
    // window is full, copy from the block start, end inside a match
    send_byte(8'h23, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b1);
    // block of a control byte alone
    send_byte(8'h5A, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    // source partly before the block start, then a long overlapping copy
    send_byte(8'h07, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hEC, 1'b0);
    send_byte(8'hF2, 1'b0);
    send_byte(8'hF3, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    while (sent < RandomUntil) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_block(($urandom_range(0, 7) == 0) ? $urandom_range(8, 14)
                                                  : $urandom_range(1, 4), 1'b0);
    end
    drain();

    // long block wraps the window; the receiver holds off at its start
    hold_req = 1'b1;
    tx_calm = 1'b1;
    send_block(0, 1'b1);
    cmp_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 50000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (64) @(posedge clk);

    $display("summary: %0d compressed bytes in %0d blocks, %0d raw bytes compared", sent,
             blocks, checked);
    $display("summary: one block past the full window, one long receiver hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("lzss_window_decompressor_tb: clean");
    end else begin
      $display("lzss_window_decompressor_tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("lzss_window_decompressor_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lzsswd_pkg.sv
rtl/lzss_window_decompressor.sv
rtl/lzsswd_checker.sv
tb/lzss_window_decompressor_checker.sv
tb/lzss_window_decompressor_tb.sv
